/* sv/position_window_lock_detector_unit_macros.svh */
// Assertion macros shared by the lock detector checker.
// Depends on nothing; the user supplies clk_i and rst_ni in scope.
`ifndef POSITION_WINDOW_LOCK_DETECTOR_UNIT_MACROS_SVH
`define POSITION_WINDOW_LOCK_DETECTOR_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PWLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define PWLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `PWLD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* sv/pwld_pkg.sv */
// Shared types and constants of the position window lock detector.
// No dependencies; used by the interfaces and all modules.
package pwld_pkg;

  localparam int unsigned WINDOW_DEPTH = 10;
  localparam int unsigned IdxW         = $clog2(WINDOW_DEPTH);
  localparam int unsigned PosW         = 16;
  localparam int unsigned CfgIdxW      = 8;
  localparam int unsigned OneQ88       = 256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STABLE_RANGE  = 8'd0,
    CFG_NEAR_MAX      = 8'd1,
    CFG_REACHED_RANGE = 8'd2,
    CFG_REACHED_MAX   = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EV_NO_CHANGE      = 2'd0,
    EV_CHASE_STARTED  = 2'd1,
    EV_TARGET_REACHED = 2'd2
  } mode_event_e;

  typedef struct packed {
    logic [PosW-1:0] stable_range;
    logic [PosW-1:0] near_max;
    logic [PosW-1:0] reached_range;
    logic [PosW-1:0] reached_max;
  } cfg_t;

  typedef struct packed {
    logic            load;
    logic            scan;
    logic [IdxW-1:0] scan_idx;
    logic            commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Window entry i holds i in Q8.8 after reset
  function automatic logic [PosW-1:0] win_reset_val(input int unsigned i);
    return PosW'(i * OneQ88);
  endfunction

endpackage

/* sv/pwld_in_if.sv */
// Input channel of the lock detector: one X/Y position pair per transfer.
// Depends on pwld_pkg.
interface pwld_in_if;
  import pwld_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] x_position;
  logic signed [PosW-1:0] y_position;

  modport source (output valid, output x_position, output y_position, input ready);
  modport sink   (input valid, input x_position, input y_position, output ready);
endinterface

/* sv/pwld_out_if.sv */
// Result channel of the lock detector: mode, event and forwarded position.
// Depends on pwld_pkg.
interface pwld_out_if;
  import pwld_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   chasing_now;
  logic [1:0]             mode_event;
  logic                   forward_valid;
  logic signed [PosW-1:0] x_out;
  logic signed [PosW-1:0] y_out;

  modport source (output valid, output chasing_now, output mode_event,
                  output forward_valid, output x_out, output y_out, input ready);
  modport sink   (input valid, input chasing_now, input mode_event,
                  input forward_valid, input x_out, input y_out, output ready);
endinterface

/* sv/pwld_cfg.sv */
// Threshold register bank of the lock detector, written through a plain port.
// Depends on pwld_pkg.
module pwld_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pwld_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pwld_pkg::PosW-1:0]      cfg_wdata_i,
  output pwld_pkg::cfg_t                 cfg_o
);
  import pwld_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STABLE_RANGE:  cfg_d.stable_range  = cfg_wdata_i;
        CFG_NEAR_MAX:      cfg_d.near_max      = cfg_wdata_i;
        CFG_REACHED_RANGE: cfg_d.reached_range = cfg_wdata_i;
        CFG_REACHED_MAX:   cfg_d.reached_max   = cfg_wdata_i;
        default:           cfg_d = cfg_q;  // drop writes past the bank
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stable_range  <= PosW'(2 * OneQ88);
      cfg_q.near_max      <= PosW'(OneQ88);
      cfg_q.reached_range <= PosW'(OneQ88);
      cfg_q.reached_max   <= PosW'(OneQ88 / 2);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

/* sv/pwld_ctrl.sv */
// Sequencer of the lock detector: accept, scan the windows, commit a result.
// Depends on pwld_pkg.
module pwld_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pwld_pkg::dp_status_t  status_i,
  output pwld_pkg::dp_cmd_t     cmd_o
);
  import pwld_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            scan_last;

  assign scan_last = (idx_q == IdxW'(WINDOW_DEPTH - 1));

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.scan_idx = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (scan_last) begin
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end
endmodule

/* sv/pwld_datapath.sv */
// Window rings, min/max scan, mode decision and output register.
// Depends on pwld_pkg; driven by pwld_ctrl commands.
module pwld_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pwld_pkg::dp_cmd_t             cmd_i,
  output pwld_pkg::dp_status_t          status_o,
  input  pwld_pkg::cfg_t                cfg_i,
  input  logic signed [pwld_pkg::PosW-1:0] x_position_i,
  input  logic signed [pwld_pkg::PosW-1:0] y_position_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          chasing_now_o,
  output logic [1:0]                    mode_event_o,
  output logic                          forward_valid_o,
  output logic signed [pwld_pkg::PosW-1:0] x_out_o,
  output logic signed [pwld_pkg::PosW-1:0] y_out_o
);
  import pwld_pkg::*;

  logic signed [PosW-1:0] x_win_q [WINDOW_DEPTH];
  logic signed [PosW-1:0] y_win_q [WINDOW_DEPTH];
  logic [IdxW-1:0]        slot_q;
  logic                   chasing_q;

  logic signed [PosW-1:0] x_hold_q, y_hold_q;
  logic signed [PosW-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [PosW-1:0] x_rd, y_rd;

  logic                   out_valid_q;
  logic                   chasing_out_q, fwd_q;
  mode_event_e            event_q, event_d;
  logic                   chasing_d;
  logic signed [PosW-1:0] x_out_q, y_out_q;

  logic [PosW-1:0]        rx, ry;
  logic signed [PosW-1:0] near_max, reached_max;
  logic                   steady, near, reached;

  // ring write and slot advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < WINDOW_DEPTH; i++) begin
        x_win_q[i] <= win_reset_val(i);
        y_win_q[i] <= win_reset_val(i);
      end
      slot_q <= '0;
    end else if (cmd_i.load) begin
      x_win_q[slot_q] <= x_position_i;
      y_win_q[slot_q] <= y_position_i;
      slot_q <= (slot_q == IdxW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_hold_q <= x_position_i;
      y_hold_q <= y_position_i;
    end
  end

  // one entry per cycle into the running min/max
  assign x_rd = x_win_q[cmd_i.scan_idx];
  assign y_rd = y_win_q[cmd_i.scan_idx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      if (cmd_i.scan_idx == '0) begin
        min_x_q <= x_rd;
        max_x_q <= x_rd;
        min_y_q <= y_rd;
        max_y_q <= y_rd;
      end else begin
        if (x_rd < min_x_q) min_x_q <= x_rd;
        if (x_rd > max_x_q) max_x_q <= x_rd;
        if (y_rd < min_y_q) min_y_q <= y_rd;
        if (y_rd > max_y_q) max_y_q <= y_rd;
      end
    end
  end

  // spread fits 0..65535 since max never falls below min
  assign rx          = max_x_q - min_x_q;
  assign ry          = max_y_q - min_y_q;
  assign near_max    = cfg_i.near_max;
  assign reached_max = cfg_i.reached_max;

  assign steady  = (rx < cfg_i.stable_range) && (ry < cfg_i.stable_range);
  assign near    = (max_x_q < near_max) && (max_y_q < near_max);
  assign reached = (rx < cfg_i.reached_range) && (ry < cfg_i.reached_range) &&
                   (max_x_q < reached_max) && (max_y_q < reached_max);

  always_comb begin
    chasing_d = chasing_q;
    event_d   = EV_NO_CHANGE;
    if (chasing_q) begin
      if (reached) begin
        chasing_d = 1'b0;
        event_d   = EV_TARGET_REACHED;
      end
    end else if (steady && !near) begin
      chasing_d = 1'b1;
      event_d   = EV_CHASE_STARTED;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chasing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        chasing_q   <= chasing_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      chasing_out_q <= chasing_d;
      event_q       <= event_d;
      fwd_q         <= chasing_q;
      x_out_q       <= x_hold_q;
      y_out_q       <= y_hold_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chasing_now_o   = chasing_out_q;
  assign mode_event_o    = event_q;
  assign forward_valid_o = fwd_q;
  assign x_out_o         = x_out_q;
  assign y_out_o         = y_out_q;
endmodule

/* sv/position_window_lock_detector_unit.sv */
// Position window lock detector.
// One transfer on pos_in brings an X/Y pair in signed Q8.8. The pair goes into
// two rings of the last WINDOW_DEPTH samples; their min and max decide whether
// the block starts or stops chasing. Every accepted pair yields exactly one
// transfer on res_out with the new mode, the mode event, the forward flag and
// a copy of the pair.
// Timing: pos_in.ready is high only while the block is idle. An accepted pair
// is written into the rings and then scanned one ring entry per cycle; its
// result is committed to the output register once that register is free, and
// the block then returns to idle, so a new pair is taken only after the last
// one is committed. The sequential scan over the ring registers sets the pace.
// A stalled receiver: the result sits in the output register; the next pair
// is still accepted and scanned, then waits until res_out takes the old one.
// The user writes thresholds through cfg_we_i/cfg_index_i/cfg_wdata_i only
// while idle, not enforced here; indexes beyond the last register are ignored.
// Reset: rings hold entry i = i in Q8.8, write slot 0, mode idle, thresholds
// at their defaults, no result pending.
// Depends on pwld_pkg, pwld_in_if, pwld_out_if, pwld_cfg, pwld_ctrl,
// pwld_datapath.
module position_window_lock_detector_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pwld_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pwld_pkg::PosW-1:0]    cfg_wdata_i,
  pwld_in_if.sink                      pos_in,
  pwld_out_if.source                   res_out
);
  import pwld_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  pwld_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pwld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pos_in.valid),
    .in_ready_o (pos_in.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pwld_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_i           (cfg),
    .x_position_i    (pos_in.x_position),
    .y_position_i    (pos_in.y_position),
    .out_ready_i     (res_out.ready),
    .out_valid_o     (res_out.valid),
    .chasing_now_o   (res_out.chasing_now),
    .mode_event_o    (res_out.mode_event),
    .forward_valid_o (res_out.forward_valid),
    .x_out_o         (res_out.x_out),
    .y_out_o         (res_out.y_out)
  );
endmodule

/* sv/pwld_chk.sv */
// Port-level checker of the lock detector and its bind to the top level.
// Depends on pwld_pkg and position_window_lock_detector_unit_macros.svh.
`include "position_window_lock_detector_unit_macros.svh"

module pwld_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       chasing_now_i,
  input logic [1:0] mode_event_i,
  input logic       forward_valid_i
);
  import pwld_pkg::*;

  // a started chase was idle at step start
  `PWLD_ASSERT(a_start_flags, out_valid_i && mode_event_i == EV_CHASE_STARTED |-> chasing_now_i && !forward_valid_i, "chase start with wrong mode flags")
  // reaching the target leaves chasing but still forwards
  `PWLD_ASSERT(a_reach_flags, out_valid_i && mode_event_i == EV_TARGET_REACHED |-> !chasing_now_i && forward_valid_i, "target reached with wrong mode flags")
  // without an event the mode is unchanged
  `PWLD_ASSERT(a_keep_mode, out_valid_i && mode_event_i == EV_NO_CHANGE |-> chasing_now_i == forward_valid_i, "mode changed without an event")
  // one item in flight: ready drops after a transfer
  `PWLD_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i, "input taken while busy")
  `PWLD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
endmodule

bind position_window_lock_detector_unit pwld_chk u_pwld_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (pos_in.valid),
  .in_ready_i      (pos_in.ready),
  .out_valid_i     (res_out.valid),
  .out_ready_i     (res_out.ready),
  .chasing_now_i   (res_out.chasing_now),
  .mode_event_i    (res_out.mode_event),
  .forward_valid_i (res_out.forward_valid)
);
